FILE: hw/rtl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types, constants and helpers of the control point trilinear splat.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int GRID_EDGE       = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int AXIS_W          = $clog2(GRID_EDGE);
  localparam int ADDR_W          = 3 * AXIS_W;
  localparam int VOX_COUNT       = GRID_EDGE * GRID_EDGE * GRID_EDGE;
  localparam int COORD_W         = 16;
  localparam int SIZE_W          = 6;
  localparam int WGT_W           = COORD_FRAC_BITS + 1;
  localparam int MAG_W           = COORD_W + 1;
  localparam int CONTRIB_W       = MAG_W + 1;
  localparam int GRAD_W          = 32;
  localparam int SSD_W           = 48;
  localparam int SQ_W            = 2 * COORD_W + 2;

  localparam logic [WGT_W-1:0]  COORD_ONE = WGT_W'(1) << COORD_FRAC_BITS;
  localparam logic [SSD_W-1:0]  SSD_MAX   = '1;
  localparam logic [SIZE_W-1:0] SIZE_EDGE = SIZE_W'(GRID_EDGE);

  typedef enum logic [1:0] {
    FUNC_SPLAT = 2'd0,
    FUNC_VOXEL = 2'd1,
    FUNC_SSD   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_SIZE_X  = 2'd0,
    REG_SIZE_Y  = 2'd1,
    REG_SIZE_Z  = 2'd2,
    REG_THREE_D = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_CORNER,
    S_DRAIN,
    S_RDV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] bent_x;
    logic [COORD_W-1:0] bent_y;
    logic [COORD_W-1:0] bent_z;
    logic [COORD_W-1:0] flat_x;
    logic [COORD_W-1:0] flat_y;
    logic [COORD_W-1:0] flat_z;
    logic [4:0]         voxel_x;
    logic [4:0]         voxel_y;
    logic [4:0]         voxel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic [SSD_W-1:0]         ssd_total;
    logic [3:0]               corners_dropped;
  } out_word_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
    logic signed [GRAD_W-1:0] z;
  } grad_t;

  typedef struct packed {
    logic              en;
    logic [2:0]        mask;
    logic [ADDR_W-1:0] addr;
    grad_t             data;
  } wr_req_t;

  // size register as used: zero acts as one, above the edge acts as the edge
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_EDGE) r = SIZE_EDGE;
    return r;
  endfunction

  // saturating add of a weighted contribution into a store entry
  function automatic logic signed [GRAD_W-1:0] sat_add(
      input logic signed [GRAD_W-1:0]    a,
      input logic signed [CONTRIB_W-1:0] c);
    logic signed [GRAD_W:0] s;
    logic signed [GRAD_W-1:0] r;
    s = {a[GRAD_W-1], a} + (GRAD_W+1)'(c);
    r = s[GRAD_W-1:0];
    if (s[GRAD_W] != s[GRAD_W-1]) begin
      r = s[GRAD_W] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/control_point_trilinear_splat.sv
// ----------------------------------------------------------------------------
// control_point_trilinear_splat
// Splats control point gradients trilinearly into three voxel memories and
// keeps a saturating sum of squared differences; reads and clears either.
// ----------------------------------------------------------------------------
// Flow: a splat passes through setup, one issue per corner (8 in 3D, 4 in 2D)
// and a drain of the corner pipeline; a voxel readout reads the memories first;
// an SSD readout or unused code goes straight to its word; one word at a time.
// Rate is set by the read-modify-write of one corner a cycle on the memories.
// Reset: control registers clear at once; the clearing pass then zeroes all
// 32768 memory entries, in_stall_o high. Configuration writes are taken meanwhile.
module control_point_trilinear_splat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cpts_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cpts_pkg::out_word_t   out_word_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import cpts_pkg::*;

  state_e state_q, state_d;

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic              three_d_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_idx;

  in_word_t          item_q;
  logic              in_acc, out_free, clear_busy;
  logic [2:0]        cnt_q;
  logic              last_corner;

  logic [SIZE_W-1:0] szx, szy, szz;
  logic [AXIS_W-1:0] base_x_q, base_y_q, base_z_q;
  logic [COORD_FRAC_BITS-1:0] frac_x_q, frac_y_q, frac_z_q;
  logic [21:0]       pos_x, pos_y, pos_z;
  logic [COORD_W-1:0] dif_x, dif_y, dif_z;
  logic [MAG_W-1:0]  mag_x_q, mag_y_q, mag_z_q;
  logic              neg_x_q, neg_y_q, neg_z_q;
  logic [SQ_W-1:0]   sq_d, sq_q;
  logic [SSD_W:0]    ssd_sum;
  logic [SSD_W-1:0]  ssd_q, ssd_d, sres_q;

  logic [SIZE_W-1:0] cx, cy, cz;
  logic              in_grid;
  logic [WGT_W-1:0]  wx, wy, wz;
  logic              v1_q, v2_q, v3_q;
  logic [ADDR_W-1:0] a1_q, a2_q, a3_q, vox_addr;
  logic signed [CONTRIB_W-1:0] cx_c, cy_c, cz_c;
  logic [3:0]        drop_q;
  grad_t             gres_q, rd_data;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  wr_req_t           wr;

  logic              out_valid_q;
  out_word_t         out_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= SIZE_EDGE;
      size_y_q  <= SIZE_EDGE;
      size_z_q  <= SIZE_EDGE;
      three_d_q <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SIZE_X:  size_x_q  <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:  size_y_q  <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:  size_z_q  <= pwdata[SIZE_W-1:0];
        REG_THREE_D: three_d_q <= pwdata[0];
        default:     three_d_q <= three_d_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SIZE_X:  prdata = 32'(size_x_q);
      REG_SIZE_Y:  prdata = 32'(size_y_q);
      REG_SIZE_Z:  prdata = 32'(size_z_q);
      REG_THREE_D: prdata = 32'(three_d_q);
      default:     prdata = '0;
    endcase
  end

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_corner = (cnt_q == (three_d_q ? 3'd7 : 3'd3));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (!clear_busy) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (func_e'(in_word_i.func))
            FUNC_SPLAT: state_d = S_SETUP;
            FUNC_VOXEL: state_d = S_RDV;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_SETUP:  state_d = S_CORNER;
      S_CORNER: if (last_corner) state_d = S_DRAIN;
      S_DRAIN:  if (!(v1_q || v2_q || v3_q)) state_d = S_DONE;
      S_RDV:    state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  // setup: base voxel, fraction, difference and squares per axis
  assign szx = clamp_size(size_x_q);
  assign szy = clamp_size(size_y_q);
  assign szz = three_d_q ? clamp_size(size_z_q) : SIZE_W'(1);

  assign pos_x = 22'(item_q.bent_x) * 22'(szx);
  assign pos_y = 22'(item_q.bent_y) * 22'(szy);
  assign pos_z = 22'(item_q.bent_z) * 22'(szz);

  assign dif_x = (item_q.flat_x >= item_q.bent_x) ? item_q.flat_x - item_q.bent_x
                                                  : item_q.bent_x - item_q.flat_x;
  assign dif_y = (item_q.flat_y >= item_q.bent_y) ? item_q.flat_y - item_q.bent_y
                                                  : item_q.bent_y - item_q.flat_y;
  assign dif_z = (item_q.flat_z >= item_q.bent_z) ? item_q.flat_z - item_q.bent_z
                                                  : item_q.bent_z - item_q.flat_z;

  always_comb begin
    sq_d = SQ_W'(dif_x) * SQ_W'(dif_x) + SQ_W'(dif_y) * SQ_W'(dif_y);
    if (three_d_q) sq_d = sq_d + SQ_W'(dif_z) * SQ_W'(dif_z);
  end

  // saturating ssd accumulate
  assign ssd_sum = (SSD_W+1)'(ssd_q) + (SSD_W+1)'(sq_q);
  assign ssd_d   = ssd_sum[SSD_W] ? SSD_MAX : ssd_sum[SSD_W-1:0];

  // corner issue: weights and bounds
  always_comb begin
    cx = SIZE_W'(base_x_q) + SIZE_W'(cnt_q[0]);
    cy = SIZE_W'(base_y_q) + SIZE_W'(cnt_q[1]);
    cz = SIZE_W'(base_z_q) + SIZE_W'(cnt_q[2]);
    in_grid = (cx < szx) && (cy < szy) && (cz < szz);
    wx = cnt_q[0] ? WGT_W'(frac_x_q) : COORD_ONE - WGT_W'(frac_x_q);
    wy = cnt_q[1] ? WGT_W'(frac_y_q) : COORD_ONE - WGT_W'(frac_y_q);
    wz = cnt_q[2] ? WGT_W'(frac_z_q) : COORD_ONE - WGT_W'(frac_z_q);
  end

  cpts_lane u_lane_x (
    .clk_i, .mag_i(mag_x_q), .neg_i(neg_x_q),
    .wx_i(wx), .wy_i(wy), .wz_i(wz), .contrib_o(cx_c)
  );
  cpts_lane u_lane_y (
    .clk_i, .mag_i(mag_y_q), .neg_i(neg_y_q),
    .wx_i(wx), .wy_i(wy), .wz_i(wz), .contrib_o(cy_c)
  );
  cpts_lane u_lane_z (
    .clk_i, .mag_i(mag_z_q), .neg_i(neg_z_q),
    .wx_i(wx), .wy_i(wy), .wz_i(wz), .contrib_o(cz_c)
  );

  // memory control
  assign vox_addr = {in_word_i.voxel_z, in_word_i.voxel_y, in_word_i.voxel_x};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = a2_q;
    wr      = '0;
    case (state_q)
      S_IDLE: begin
        rd_en   = in_acc && (func_e'(in_word_i.func) == FUNC_VOXEL);
        rd_addr = vox_addr;
      end
      S_CORNER, S_DRAIN: begin
        rd_en     = v2_q;
        wr.en     = v3_q;
        wr.mask   = {three_d_q, 2'b11};
        wr.addr   = a3_q;
        wr.data.x = sat_add(rd_data.x, cx_c);
        wr.data.y = sat_add(rd_data.y, cy_c);
        wr.data.z = sat_add(rd_data.z, cz_c);
      end
      S_RDV: begin
        wr.en   = 1'b1;
        wr.mask = 3'b111;
        wr.addr = {item_q.voxel_z, item_q.voxel_y, item_q.voxel_x};
      end
      default: rd_en = 1'b0;
    endcase
  end

  cpts_store u_store (
    .clk_i,
    .rst_ni,
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data),
    .wr_i         (wr),
    .clear_busy_o (clear_busy)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      ssd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= (state_q == S_CORNER) && in_grid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == S_CORNER) cnt_q <= cnt_q + 3'd1;
      else                     cnt_q <= '0;
      if (state_q == S_CORNER && cnt_q == 3'd0) ssd_q <= ssd_d;
      if (in_acc && func_e'(in_word_i.func) == FUNC_SSD) ssd_q <= '0;
      if (state_q == S_DONE && out_free)  out_valid_q <= 1'b1;
      else if (!out_stall_i)              out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a1_q <= {cz[AXIS_W-1:0], cy[AXIS_W-1:0], cx[AXIS_W-1:0]};
    a2_q <= a1_q;
    a3_q <= a2_q;
    if (in_acc) begin
      item_q <= in_word_i;
      gres_q <= '0;
      drop_q <= '0;
      sres_q <= (func_e'(in_word_i.func) == FUNC_SSD) ? ssd_q : '0;
    end
    if (state_q == S_SETUP) begin
      base_x_q <= pos_x[COORD_FRAC_BITS +: AXIS_W];
      base_y_q <= pos_y[COORD_FRAC_BITS +: AXIS_W];
      base_z_q <= three_d_q ? pos_z[COORD_FRAC_BITS +: AXIS_W] : '0;
      frac_x_q <= pos_x[COORD_FRAC_BITS-1:0];
      frac_y_q <= pos_y[COORD_FRAC_BITS-1:0];
      frac_z_q <= three_d_q ? pos_z[COORD_FRAC_BITS-1:0] : '0;
      mag_x_q  <= {dif_x, 1'b0};
      mag_y_q  <= {dif_y, 1'b0};
      mag_z_q  <= {dif_z, 1'b0};
      neg_x_q  <= item_q.bent_x > item_q.flat_x;
      neg_y_q  <= item_q.bent_y > item_q.flat_y;
      neg_z_q  <= item_q.bent_z > item_q.flat_z;
      sq_q     <= sq_d;
    end
    if (state_q == S_CORNER) begin
      if (cnt_q == 3'd0) sres_q <= ssd_d;
      if (!in_grid)      drop_q <= drop_q + 4'd1;
    end
    if (state_q == S_RDV) gres_q <= rd_data;
    if (state_q == S_DONE && out_free) begin
      out_q.grad_x          <= gres_q.x;
      out_q.grad_y          <= gres_q.y;
      out_q.grad_z          <= gres_q.z;
      out_q.ssd_total       <= sres_q;
      out_q.corners_dropped <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> in_stall_o)
    else $error("item accepted during clearing pass");

  a_pipe_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(v1_q || v2_q || v3_q))
    else $error("corner pipeline busy while idle");

  a_drop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.corners_dropped <= 4'd8))
    else $error("more corners dropped than a splat has");

endmodule

FILE: hw/rtl/cpts_lane.sv
// ----------------------------------------------------------------------------
// cpts_lane
// Three-stage weighting pipeline of one axis: magnitude times wx, wy, wz,
// each product rounded half up back to the coordinate fraction, then signed.
// ----------------------------------------------------------------------------
module cpts_lane (
  input  logic                              clk_i,
  input  logic [cpts_pkg::MAG_W-1:0]        mag_i,
  input  logic                              neg_i,
  input  logic [cpts_pkg::WGT_W-1:0]        wx_i,
  input  logic [cpts_pkg::WGT_W-1:0]        wy_i,
  input  logic [cpts_pkg::WGT_W-1:0]        wz_i,
  output logic signed [cpts_pkg::CONTRIB_W-1:0] contrib_o
);
  import cpts_pkg::*;

  localparam int PROD_W = MAG_W + WGT_W;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (COORD_FRAC_BITS - 1);

  logic [MAG_W-1:0] m1_q, m2_q;
  logic             neg1_q, neg2_q;
  logic [WGT_W-1:0] wy1_q, wz1_q, wz2_q;
  logic [PROD_W-1:0] p1, p2, p3;
  logic signed [CONTRIB_W-1:0] c_d, c_q;

  // rounded products, one per stage
  assign p1 = PROD_W'(mag_i) * PROD_W'(wx_i) + HALF;
  assign p2 = PROD_W'(m1_q) * PROD_W'(wy1_q) + HALF;
  assign p3 = PROD_W'(m2_q) * PROD_W'(wz2_q) + HALF;

  always_comb begin
    c_d = $signed({1'b0, p3[COORD_FRAC_BITS +: MAG_W]});
    if (neg2_q) c_d = -c_d;
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    m1_q   <= p1[COORD_FRAC_BITS +: MAG_W];
    neg1_q <= neg_i;
    wy1_q  <= wy_i;
    wz1_q  <= wz_i;
    m2_q   <= p2[COORD_FRAC_BITS +: MAG_W];
    neg2_q <= neg1_q;
    wz2_q  <= wz1_q;
    c_q    <= c_d;
  end

  assign contrib_o = c_q;

endmodule

FILE: hw/rtl/cpts_store.sv
// ----------------------------------------------------------------------------
// cpts_store
// The three per-axis gradient memories: one registered read port, one
// masked write port, and a clearing pass over every entry after reset.
// ----------------------------------------------------------------------------
module cpts_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [cpts_pkg::ADDR_W-1:0]   rd_addr_i,
  output cpts_pkg::grad_t               rd_data_o,
  input  cpts_pkg::wr_req_t             wr_i,
  output logic                          clear_busy_o
);
  import cpts_pkg::*;

  logic signed [GRAD_W-1:0] mem_x [VOX_COUNT];
  logic signed [GRAD_W-1:0] mem_y [VOX_COUNT];
  logic signed [GRAD_W-1:0] mem_z [VOX_COUNT];

  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  wr_req_t           wr;
  grad_t             rd_q;

  // clearing sweep, one entry a cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(VOX_COUNT - 1)) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // write port, the sweep has priority
  always_comb begin
    wr = wr_i;
    if (clr_busy_q) begin
      wr.en   = 1'b1;
      wr.mask = 3'b111;
      wr.addr = clr_addr_q;
      wr.data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      if (wr.mask[0]) mem_x[wr.addr] <= wr.data.x;
      if (wr.mask[1]) mem_y[wr.addr] <= wr.data.y;
      if (wr.mask[2]) mem_z[wr.addr] <= wr.data.z;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.x <= mem_x[rd_addr_i];
      rd_q.y <= mem_y[rd_addr_i];
      rd_q.z <= mem_z[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_q;
  assign clear_busy_o = clr_busy_q;

endmodule
